FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the time converter.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that holds at every sampled edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that the given expression is never true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

FILE: rtl/core/rttc_pkg.sv
`default_nettype none

package rttc_pkg;

   // Field widths of the timestamp and the trim rate.
   localparam int TIME_W = 64;
   localparam int RATE_W = 32;
   localparam int FRAC_W = 32;

   // Operation codes of a request transaction.
   typedef enum logic {
      OP_CONVERT = 1'b0,
      OP_SET     = 1'b1
   } op_type;

   // Request transaction payload.
   typedef struct packed {
      op_type                    op;
      logic [TIME_W-1:0]         mono_time;
      logic signed [RATE_W-1:0]  new_rate;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [TIME_W-1:0]         trimmed_time;
      logic signed [RATE_W-1:0]  current_rate;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/rate_trimmed_time_converter.sv
// Converts a 64-bit monotonic timestamp into trimmed time, mono + offset +
// floor((mono - ref) * rate / 2^32), with rate a signed 0.32 fraction. A set
// transaction folds the correction gathered since the reference instant into the
// offset, keeps the 32-bit fractional remainder, moves the reference to its
// timestamp and installs the new rate; its response is the timestamp plus the
// updated offset. The block takes one transaction per cycle while the response side
// does not stall and passes each one through an input register, a stage of two 32x32
// partial products, a stage that sums and signs the product, and the response
// register where the offset is added. Rate and reference are updated as a set
// leaves the input register, the offset and remainder as it enters the response
// register, so transactions that follow each other closely see the state in order.
// Each stage holds its transaction on its own, so bubbles close up while the
// response side stalls.

`default_nettype none

module rate_trimmed_time_converter
   import rttc_pkg::*;
(
   input  wire  logic    clock,
   input  wire  logic    reset,
   input  wire  logic    req_valid,
   output       logic    req_stall,
   input  wire  req_type req_data,
   output       logic    rsp_valid,
   input  wire  logic    rsp_stall,
   output       rsp_type rsp_data
);

`include "assert_macros.svh"

   // Converter state.
   logic [RATE_W-1:0] rate_ff;
   logic [RATE_W-1:0] rate_in;
   logic [TIME_W-1:0] ref_ff;
   logic [TIME_W-1:0] ref_in;
   logic [TIME_W-1:0] offset_ff;
   logic [TIME_W-1:0] offset_in;
   logic [FRAC_W-1:0] rem_ff;
   logic [FRAC_W-1:0] rem_in;

   // Stage valid bits.
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic rsp_valid_ff;

   // Stage payloads.
   req_type           s1_ff;
   op_type            s2_op_ff;
   logic [TIME_W-1:0] s2_mono_ff;
   logic [RATE_W-1:0] s2_rate_ff;
   logic [TIME_W-1:0] s2_pp_lo_ff;
   logic [FRAC_W-1:0] s2_pp_hi_ff;
   logic              s2_neg_ff;
   op_type            s3_op_ff;
   logic [TIME_W-1:0] s3_mono_ff;
   logic [RATE_W-1:0] s3_rate_ff;
   logic [TIME_W-1:0] s3_prod_ff;
   rsp_type           rsp_ff;

   // Per-stage flow control.
   logic ready_out;
   logic ready3;
   logic ready2;
   logic ready1;
   logic s1_fire;
   logic s2_fire;
   logic s3_fire;

   assign ready_out = !rsp_valid_ff || !rsp_stall;
   assign ready3    = !s3_valid_ff || ready_out;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign s1_fire   = s1_valid_ff && ready2;
   assign s2_fire   = s2_valid_ff && ready3;
   assign s3_fire   = s3_valid_ff && ready_out;

   assign req_stall = !ready1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Delta to the reference instant in sign and magnitude form, and partial products.
   logic [TIME_W-1:0] delta;
   logic [TIME_W-1:0] delta_mag;
   logic [RATE_W-1:0] rate_mag;
   logic              neg_in;
   logic [TIME_W-1:0] pp_lo_in;
   logic [FRAC_W-1:0] pp_hi_in;

   always_comb begin
      delta     = s1_ff.mono_time - ref_ff;
      delta_mag = delta[TIME_W-1] ? (TIME_W'(0) - delta) : delta;
      rate_mag  = rate_ff[RATE_W-1] ? (RATE_W'(0) - rate_ff) : rate_ff;
      neg_in    = delta[TIME_W-1] ^ rate_ff[RATE_W-1];
      pp_lo_in  = TIME_W'(delta_mag[31:0]) * TIME_W'(rate_mag);
      // Only the low half of the upper partial product survives the truncation.
      pp_hi_in  = delta_mag[63:32] * rate_mag;
   end

   // A set transaction moves the reference and rate as it leaves the input register.
   always_comb begin
      rate_in = rate_ff;
      ref_in  = ref_ff;
      if (s1_fire && (s1_ff.op == OP_SET)) begin
         rate_in = s1_ff.new_rate;
         ref_in  = s1_ff.mono_time;
      end
   end

   // Product magnitude, truncated to 64 bits, with the sign applied.
   logic [TIME_W-1:0] prod_mag;
   logic [TIME_W-1:0] prod_in;

   always_comb begin
      prod_mag = s2_pp_lo_ff + {s2_pp_hi_ff, FRAC_W'(0)};
      prod_in  = s2_neg_ff ? (TIME_W'(0) - prod_mag) : prod_mag;
   end

   // Correction with the carried remainder for a set, then the trimmed time.
   logic [TIME_W-1:0] corr_sum;
   logic [TIME_W-1:0] corr;
   rsp_type           rsp_in;

   always_comb begin
      if (s3_op_ff == OP_SET) begin
         corr_sum = s3_prod_ff + TIME_W'(rem_ff);
      end else begin
         corr_sum = s3_prod_ff;
      end
      corr = {{FRAC_W{corr_sum[TIME_W-1]}}, corr_sum[TIME_W-1:FRAC_W]};
      rsp_in.trimmed_time = s3_mono_ff + offset_ff + corr;
      rsp_in.current_rate = s3_rate_ff;
      offset_in = offset_ff;
      rem_in    = rem_ff;
      if (s3_fire && (s3_op_ff == OP_SET)) begin
         offset_in = offset_ff + corr;
         rem_in    = corr_sum[FRAC_W-1:0];
      end
   end

   // Valid bits and converter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= '0;
         ref_ff       <= '0;
         offset_ff    <= '0;
         rem_ff       <= '0;
      end else begin
         if (ready1) begin
            s1_valid_ff <= req_valid;
         end
         if (ready2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ready3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (ready_out) begin
            rsp_valid_ff <= s3_valid_ff;
         end
         rate_ff   <= rate_in;
         ref_ff    <= ref_in;
         offset_ff <= offset_in;
         rem_ff    <= rem_in;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (ready1 && req_valid) begin
         s1_ff <= req_data;
      end
      if (s1_fire) begin
         s2_op_ff    <= s1_ff.op;
         s2_mono_ff  <= s1_ff.mono_time;
         s2_rate_ff  <= rate_in;
         s2_pp_lo_ff <= pp_lo_in;
         s2_pp_hi_ff <= pp_hi_in;
         s2_neg_ff   <= neg_in;
      end
      if (s2_fire) begin
         s3_op_ff   <= s2_op_ff;
         s3_mono_ff <= s2_mono_ff;
         s3_rate_ff <= s2_rate_ff;
         s3_prod_ff <= prod_in;
      end
      if (s3_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // A transaction in the last stage is never dropped while the response register is held.
   `ASSERT_CLK(a_s3_hold, (s3_valid_ff && !ready_out) |=> s3_valid_ff,
      "Stage three transaction lost while the response was stalled.")

   // Offset and remainder move only when a set transaction enters the response register.
   `ASSERT_CLK(a_offset_stable, !(s3_fire && (s3_op_ff == OP_SET)) |=>
      ($stable(offset_ff) && $stable(rem_ff)),
      "Offset or remainder changed without a set transaction.")

   // Reference and rate move only when a set transaction leaves the input register.
   `ASSERT_CLK(a_ref_stable, !(s1_fire && (s1_ff.op == OP_SET)) |=>
      ($stable(ref_ff) && $stable(rate_ff)),
      "Reference or rate changed without a set transaction.")

   // A response register that is full and stalled never takes a new transaction.
   `ASSERT_NEVER(a_no_overwrite, rsp_valid_ff && rsp_stall && s3_fire,
      "Response register overwritten while stalled.")

endmodule

`default_nettype wire

FILE: dv/trimmed_time_checker.sv
// Watches both channels of the time converter. It predicts the trimmed time of
// every accepted request and compares each accepted response with the oldest
// prediction.
module trimmed_time_checker
   import rttc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           mismatches,
   output int           outstanding
);

   // Predicted converter state.
   logic signed [RATE_W-1:0] rate_now;
   logic [TIME_W-1:0]        ref_now;
   logic [TIME_W-1:0]        offset_now;
   logic [FRAC_W-1:0]        frac_now;

   // Predicted responses, oldest first.
   rsp_type expected_results[$];

   req_type           item;
   rsp_type           want;
   rsp_type           got;
   logic [TIME_W-1:0] product;

   // Signed product of delta and rate in 32.32 form. The magnitudes are
   // multiplied and truncated to 64 bits, and then the sign is applied.
   function automatic logic [63:0] rate_product(input logic [31:0] rate,
                                                input logic [63:0] delta);
      logic        negative;
      logic [63:0] delta_mag;
      logic [31:0] rate_mag;
      logic [63:0] mag_product;
      negative    = delta[63] ^ rate[31];
      delta_mag   = delta[63] ? 64'd0 - delta : delta;
      rate_mag    = rate[31] ? 32'd0 - rate : rate;
      mag_product = delta_mag * {32'd0, rate_mag};
      return negative ? 64'd0 - mag_product : mag_product;
   endfunction

   // Prints one line for a mismatch and counts it. The printing stops after
   // a while so that a broken block does not flood the log.
   task automatic report_mismatch(input string what, input logic [63:0] seen,
                                  input logic [63:0] wanted);
      if (mismatches < 40) begin
         $display("%0t: %s: got %h, expected %h", $time, what, seen, wanted);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rate_now   = '0;
         ref_now    = '0;
         offset_now = '0;
         frac_now   = '0;
         expected_results.delete();
      end else begin
         // Compare a response before any new prediction is queued, since a
         // response never belongs to a request accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_results.size() == 0) begin
               report_mismatch("response with no transaction pending",
                               got.trimmed_time, '0);
            end else begin
               want = expected_results.pop_front();
               if (got.trimmed_time !== want.trimmed_time) begin
                  report_mismatch("trimmed_time", got.trimmed_time, want.trimmed_time);
               end
               if (got.current_rate !== want.current_rate) begin
                  report_mismatch("current_rate", 64'(got.current_rate),
                                  64'(want.current_rate));
               end
            end
         end

         // Predict the response of an accepted request.
         if (req_valid && !req_stall) begin
            item = req_data;
            if (item.op == OP_SET) begin
               // Fold the correction gathered since the reference instant into
               // the offset and keep its fractional part for the next set.
               product    = rate_product(rate_now, item.mono_time - ref_now)
                            + {32'd0, frac_now};
               frac_now   = product[31:0];
               offset_now = offset_now + {{32{product[63]}}, product[63:32]};
               ref_now    = item.mono_time;
               rate_now   = item.new_rate;
            end
            product           = rate_product(rate_now, item.mono_time - ref_now);
            want.trimmed_time = item.mono_time + {{32{product[63]}}, product[63:32]}
                                + offset_now;
            want.current_rate = rate_now;
            expected_results.push_back(want);
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

FILE: dv/tb_rate_trimmed_time_converter.sv
module tb_rate_trimmed_time_converter;
   import rttc_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;

   // Percent of cycles in which each side holds off.
   int send_idle_pct = 0;
   int hold_idle_pct = 0;

   // Monotonic time that the well-formed random traffic follows.
   logic [63:0] mono_now = '0;

   rate_trimmed_time_converter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   trimmed_time_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // The response side stalls at random.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < hold_idle_pct);
   end

   // Offers one request transaction, after random idle cycles, and returns at
   // the edge where it is accepted.
   task automatic send_req(input op_type op, input logic [63:0] mono,
                           input logic [31:0] rate);
      req_type item;
      item.op        = op;
      item.mono_time = mono;
      item.new_rate  = rate;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Holds the sender off until every predicted response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] random_time();
      return {$urandom, $urandom};
   endfunction

   // Mostly a plausible time line with small rate trims, some fully random
   // transactions and some corner values.
   task automatic random_reqs(input int count);
      int          kind;
      op_type      op;
      logic [63:0] mono;
      logic [31:0] rate;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            mono_now = mono_now + 64'($urandom_range(1 << 20));
            op       = ($urandom_range(99) < 20) ? OP_SET : OP_CONVERT;
            mono     = mono_now;
            if (op == OP_CONVERT && $urandom_range(3) == 0) begin
               mono = mono_now - 64'($urandom_range(1 << 16));
            end
            if ($urandom_range(3) == 0) begin
               rate = $urandom;
            end else begin
               rate = 32'(int'($urandom_range(1 << 21)) - (1 << 20));
            end
         end else if (kind < 88) begin
            op   = op_type'($urandom_range(1));
            mono = random_time();
            rate = $urandom;
            if (op == OP_SET) begin
               mono_now = mono;
            end
         end else begin
            op = op_type'($urandom_range(1));
            case ($urandom_range(3))
               0: mono = '0;
               1: mono = '1;
               2: mono = 64'h8000_0000_0000_0000;
               default: mono = mono_now + 64'h8000_0000_0000_0000;
            endcase
            case ($urandom_range(3))
               0: rate = 32'h8000_0000;
               1: rate = 32'h7FFF_FFFF;
               2: rate = 32'hFFFF_FFFF;
               default: rate = '0;
            endcase
         end
         send_req(op, mono, rate);
      end
   endtask

   // Stimulus and verdict.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      hold_idle_pct = 68;

      // Directed corners: extreme times and rates, a delta of minus two to the
      // 63rd, overflowing products and sums, back-to-back sets that carry the
      // fractional remainder, and converts that ignore their rate field.
      send_req(OP_CONVERT, 64'd0, 32'd0);
      send_req(OP_CONVERT, '1, '1);
      send_req(OP_SET, 64'd1000, 32'h8000_0000);
      send_req(OP_CONVERT, 64'd1000 + (64'd1 << 40), 32'd0);
      send_req(OP_CONVERT, 64'd995, 32'h7FFF_FFFF);
      send_req(OP_CONVERT, 64'd1000 + (64'd1 << 63), 32'd0);
      send_req(OP_SET, '1, 32'h7FFF_FFFF);
      send_req(OP_CONVERT, 64'd0, 32'd0);
      send_req(OP_CONVERT, 64'h7FFF_FFFF_FFFF_FFFE, 32'd0);
      send_req(OP_CONVERT, 64'h8000_0000_0000_0000, 32'd0);
      send_req(OP_SET, 64'd5, 32'd1);
      send_req(OP_SET, 64'd5, 32'd3);
      send_req(OP_SET, 64'd1_000_005, 32'hFFFF_FFFF);
      send_req(OP_SET, 64'd3_000_007, 32'h0000_1234);
      send_req(OP_CONVERT, 64'd2_999_000, 32'h0);
      send_req(OP_SET, 64'h8000_0000_0000_0000, 32'h8000_0000);
      send_req(OP_SET, 64'd1, 32'd0);
      send_req(OP_CONVERT, 64'hFFFF_FFFF_0000_0000, '1);
      send_req(OP_SET, 64'd0, 32'h0001_0000);
      mono_now = '0;

      random_reqs(140);
      drain_responses();

      send_idle_pct = 68;
      hold_idle_pct = 16;
      random_reqs(150);
      drain_responses();

      send_idle_pct = 0;
      hold_idle_pct = 0;
      random_reqs(150);

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
